>>> sv/cpa_pkg.sv
package cpa_pkg;
  localparam int NUM_PAGES = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CNT_W = 11;
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam logic [CNT_W-1:0] NUM_PAGES_C = CNT_W'(NUM_PAGES);

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_COUNT = 3'd1;
  localparam logic [2:0] ST_NO_MEMORY = 3'd2;
  localparam logic [2:0] ST_BAD_FREE = 3'd3;
  localparam logic [2:0] ST_NULL_FREE = 3'd4;

  localparam logic CFG_USABLE = 1'b0;
  localparam logic CFG_HEAP = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  // one descriptor word: taken bit and run length
  typedef struct packed {
    logic taken;
    logic [CNT_W-1:0] len;
  } desc_t;
endpackage

>>> sv/contiguous_page_allocator.sv
// First-fit contiguous page allocator. After reset the block clears its
// descriptor memory, one page per cycle (NUM_PAGES pages, 1024 by default),
// and takes no request until that pass is done; configuration writes are
// taken at any time. Each request gives one result. An allocate reads the
// descriptors one per cycle from page 0 until it finds the run or reaches
// usable_pages (capped at NUM_PAGES), then writes the run back one page per
// cycle. A free reads the first page, then clears the run one page per
// cycle. One request is worked on at a time.
module contiguous_page_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [63:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [cpa_pkg::CNT_W-1:0] in_page_count,
  input  logic [63:0]               in_free_address,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [63:0]               out_run_address,
  output logic [cpa_pkg::CNT_W-1:0] out_run_pages
);
  import cpa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FCLR  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  desc_t mem [NUM_PAGES];
  desc_t rd_q;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] usable_r;
  logic [63:0]      heap_r;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;    // read address of the scan
  logic [CNT_W-1:0] chk_r, chk_nxt;    // index whose data is in rd_q
  logic             chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [2:0]       st_r, st_nxt;
  logic [63:0]      addr_r, addr_nxt;
  logic [CNT_W-1:0] pages_r, pages_nxt;
  logic             ov_r, ov_nxt;

  logic             re, we;
  logic [IDX_W-1:0] ra, wa;
  desc_t            wd;

  logic [63:0] diff;
  logic [63:0] pidx;
  logic [CNT_W-1:0] run_inc;

  assign lim = (usable_r > NUM_PAGES_C) ? NUM_PAGES_C : usable_r;
  assign diff = in_free_address - heap_r;
  assign pidx = diff >> OFF_W;
  assign run_inc = run_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= NUM_PAGES_C;
      heap_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USABLE: usable_r <= cfg_wdata[CNT_W-1:0];
        CFG_HEAP:   heap_r <= cfg_wdata;
        default:    heap_r <= heap_r;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_run_address = addr_r;
  assign out_run_pages = pages_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt = ptr_r;
    chk_nxt = chk_r;
    chk_v_nxt = 1'b0;
    run_nxt = run_r;
    start_nxt = start_r;
    left_nxt = left_r;
    st_nxt = st_r;
    addr_nxt = addr_r;
    pages_nxt = pages_r;
    ov_nxt = ov_r && !out_ready;
    re = 1'b0;
    ra = ptr_r[IDX_W-1:0];
    we = 1'b0;
    wa = ptr_r[IDX_W-1:0];
    wd = '0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + CNT_W'(1);
        if (ptr_r == NUM_PAGES_C - CNT_W'(1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ptr_nxt = '0;
          run_nxt = '0;
          st_nxt = ST_OK;
          addr_nxt = '0;
          pages_nxt = '0;
          state_nxt = S_DONE;
          if (in_op == OP_ALLOC) begin
            count_nxt = in_page_count;
            if (in_page_count == '0) st_nxt = ST_BAD_COUNT;
            else if (in_page_count > lim) st_nxt = ST_NO_MEMORY;
            else state_nxt = S_SCAN;
          end else begin
            if (in_free_address == 64'd0) st_nxt = ST_NULL_FREE;
            else if (in_free_address < heap_r) st_nxt = ST_BAD_FREE;
            else if (pidx >= 64'(lim)) st_nxt = ST_BAD_FREE;
            else begin
              ptr_nxt = pidx[CNT_W-1:0];
              re = 1'b1;
              ra = pidx[IDX_W-1:0];
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_SCAN: begin
        // issue reads while checking the previous one
        if (ptr_r < lim) begin
          re = 1'b1;
          chk_v_nxt = 1'b1;
          chk_nxt = ptr_r;
          ptr_nxt = ptr_r + CNT_W'(1);
        end
        if (chk_v_r) begin
          if (rd_q.taken) run_nxt = '0;
          else begin
            run_nxt = run_inc;
            if (run_inc == count_r) begin
              start_nxt = chk_r + CNT_W'(1) - count_r;
              ptr_nxt = chk_r + CNT_W'(1) - count_r;
              left_nxt = count_r;
              chk_v_nxt = 1'b0;
              addr_nxt = heap_r + ({53'd0, chk_r + CNT_W'(1) - count_r} << OFF_W);
              pages_nxt = count_r;
              state_nxt = S_MARK;
            end
          end
        end else if (ptr_r >= lim) begin
          st_nxt = ST_NO_MEMORY;
          state_nxt = S_DONE;
        end
        if (state_nxt == S_SCAN && chk_v_r && !chk_v_nxt && ptr_r >= lim &&
            !(!rd_q.taken && run_inc == count_r)) begin
          st_nxt = ST_NO_MEMORY;
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        we = 1'b1;
        wd.taken = 1'b1;
        wd.len = (ptr_r == start_r) ? count_r : '0;
        ptr_nxt = ptr_r + CNT_W'(1);
        left_nxt = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1)) state_nxt = S_DONE;
      end
      S_FRD: begin
        if (!rd_q.taken || rd_q.len == '0) begin
          st_nxt = ST_BAD_FREE;
          state_nxt = S_DONE;
        end else begin
          pages_nxt = rd_q.len;
          left_nxt = rd_q.len;
          state_nxt = S_FCLR;
        end
      end
      S_FCLR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + CNT_W'(1);
        left_nxt = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1) || ptr_r == NUM_PAGES_C - CNT_W'(1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r <= '0;
      chk_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      chk_v_r <= chk_v_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    chk_r <= chk_nxt;
    run_r <= run_nxt;
    start_r <= start_nxt;
    left_r <= left_nxt;
    st_r <= st_nxt;
    addr_r <= addr_nxt;
    pages_r <= pages_nxt;
  end
endmodule
